// ===== design/gc_pkg.sv =====
// Shared constants, codes and the configuration bundle of the Golomb codec.
`timescale 1ns / 1ps
package gc_pkg;

    localparam int DATA_W    = 64;              // operand and result word
    localparam int DIV_W     = 32;              // divisor register
    localparam int LEN_W     = 7;               // bit length, 0..64 plus headroom
    localparam int Q_W       = 6;               // quotient, 0..63
    localparam int BW_W      = 6;               // remainder width, 0..32
    localparam int PROD_W    = Q_W + DIV_W;     // q * m
    localparam int WORD_BITS = 64;              // usable bits of a code

    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);
    localparam logic [LEN_W-1:0]  WORD_LEN  = LEN_W'(WORD_BITS);

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef struct packed {
        logic [DIV_W-1:0] m;        // effective divisor, zero read as one
        logic [BW_W-1:0]  bw;       // ceil(log2 m)
        logic [DIV_W-1:0] cutoff;   // 2^bw - m
    } cfg_t;

endpackage

// ===== design/gc_cfg.sv =====
// Divisor register and the remainder width and cutoff derived from it.
`timescale 1ns / 1ps
module gc_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [gc_pkg::DIV_W-1:0]  cfg_wr_data,
    output gc_pkg::cfg_t              cfg
);
    import gc_pkg::*;

    logic [DIV_W-1:0] divisor_reg;
    logic [BW_W-1:0]  bw_reg, bw_next;
    logic [DIV_W-1:0] cutoff_reg, cutoff_next;
    logic [DIV_W-1:0] m_eff, m_dec;
    logic [DIV_W:0]   pow_bw;

    assign m_eff = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
    assign m_dec = m_eff - DIV_W'(1);

    // ceil(log2 m) = index of the top one of m-1, plus one
    always_comb begin
        bw_next = '0;
        for (int i = 0; i < DIV_W; i++) begin
            if (m_dec[i]) bw_next = BW_W'(i + 1);
        end
        pow_bw      = (DIV_W + 1)'(1) << bw_next;
        cutoff_next = DIV_W'(pow_bw - {1'b0, m_eff});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= DIV_W'(1);
            bw_reg      <= '0;
            cutoff_reg  <= '0;
        end else begin
            if (cfg_wr_en) divisor_reg <= cfg_wr_data;
            bw_reg     <= bw_next;
            cutoff_reg <= cutoff_next;
        end
    end

    // m feeds the first stage straight away; bw and cutoff are registered,
    // which is harmless as they are needed from the third stage on
    assign cfg.m      = m_eff;
    assign cfg.bw     = bw_reg;
    assign cfg.cutoff = cutoff_reg;

endmodule

// ===== design/golomb_codec.sv =====
// Top level: four-stage Golomb encoder/decoder with truncated binary remainder.
`timescale 1ns / 1ps
// Usage
//   Input channel (s_valid/s_ready): one word per item, s_func selects
//   encode (value in s_operand) or decode (LSB-first code window).
//   Result channel (m_valid/m_ready): codeword or decoded value, the number
//   of code bits, and an error flag (code longer than 64 bits, or no
//   terminating zero in the window); on error word and length read zero.
//   Config: cfg_wr_en/cfg_wr_data write the divisor M; write only while the
//   pipeline is empty. Zero is taken as one.
// Timing
//   Four register stages: st1, st2, st3, output. Throughput is one word
//   per cycle unless m_ready stalls; the depth is set by the quotient,
//   found by restoring division two bits per stage over the first three.
//   Each stage holds its own valid bit, so bubbles are squeezed out and a
//   new word is taken while a finished result waits at the output.
// Reset
//   aresetn (synchronous, low) empties the pipeline and sets M to one.
// Stall
//   With m_ready low the result holds; the stages behind it fill up and
//   s_ready drops only once every stage is occupied.
module golomb_codec (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [gc_pkg::DATA_W-1:0]  s_operand,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [gc_pkg::DATA_W-1:0]  m_result_word,
    output logic [gc_pkg::LEN_W-1:0]   m_bit_length,
    output logic                       m_error,
    input  logic                       cfg_wr_en,
    input  logic [gc_pkg::DIV_W-1:0]   cfg_wr_data
);
    import gc_pkg::*;

    // stage 1: encode has overflow and q[5:4]; decode has lowest-zero one-hot
    typedef struct packed {
        logic              func;
        logic              err;
        logic [Q_W-1:0]    q;
        logic [DATA_W-1:0] data;    // running remainder, or masked window
        logic [DATA_W-1:0] iso;     // one-hot of the terminator
    } st1_t;

    // stage 2: encode has q[3:2]; decode has q as a number
    typedef struct packed {
        logic              func;
        logic              err;
        logic [Q_W-1:0]    q;
        logic [DATA_W-1:0] data;
    } st2_t;

    // stage 3: full quotient and remainder field
    typedef struct packed {
        logic              func;
        logic              err;
        logic [Q_W-1:0]    q;
        logic [DIV_W-1:0]  r;
        logic              b;       // trailing remainder bit on decode
        logic [PROD_W-1:0] prod;    // q * m on decode
    } st3_t;

    cfg_t cfg;

    gc_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cfg        (cfg)
    );

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [DATA_W:0] div_step(input logic [DATA_W-1:0] rem,
                                                 input logic [DATA_W-1:0] dsh);
        logic [DATA_W:0] res;
        if (rem >= dsh) res = {1'b1, rem - dsh};
        else            res = {1'b0, rem};
        return res;
    endfunction

    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    logic [DATA_W-1:0] m_result_word_reg, m_result_word_next;
    logic [LEN_W-1:0]  m_bit_length_reg, m_bit_length_next;
    logic              m_error_reg, m_error_next;

    logic [DATA_W-1:0] m_wide;
    assign m_wide = DATA_W'(cfg.m);

    // a stage takes a new word when it is empty or its word moves on
    assign rdy4    = !m_valid_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // ---- stage 1 ----
    always_comb begin
        logic [DATA_W-1:0] w;
        logic [DATA_W:0]   s5, s4;
        w  = s_operand & WORD_MASK;
        s5 = div_step(s_operand, m_wide << 5);
        s4 = div_step(s5[DATA_W-1:0], m_wide << 4);
        st1_next      = '0;
        st1_next.func = s_func;
        if (s_func == FUNC_ENCODE) begin
            // q >= WORD_BITS is an error; otherwise rem < WORD_BITS * m
            st1_next.err  = s_operand >= (m_wide * DATA_W'(WORD_BITS));
            st1_next.q    = {s5[DATA_W], s4[DATA_W], 4'b0000};
            st1_next.data = s4[DATA_W-1:0];
        end else begin
            st1_next.err  = &(w | ~WORD_MASK);
            st1_next.data = w;
            st1_next.iso  = ~w & (w + DATA_W'(1));
        end
    end

    // ---- stage 2 ----
    always_comb begin
        logic [DATA_W:0] s3, s2;
        logic [Q_W-1:0]  qd;
        s3 = div_step(st1_reg.data, m_wide << 3);
        s2 = div_step(s3[DATA_W-1:0], m_wide << 2);
        qd = '0;
        for (int i = 0; i < DATA_W; i++) begin
            qd = qd | (st1_reg.iso[i] ? Q_W'(i) : Q_W'(0));
        end
        st2_next.func = st1_reg.func;
        st2_next.err  = st1_reg.err;
        if (st1_reg.func == FUNC_ENCODE) begin
            st2_next.q    = {st1_reg.q[5:4], s3[DATA_W], s2[DATA_W], 2'b00};
            st2_next.data = s2[DATA_W-1:0];
        end else begin
            st2_next.q    = qd;
            st2_next.data = st1_reg.data;
        end
    end

    // ---- stage 3 ----
    always_comb begin
        logic [DATA_W:0]   s1, s0;
        logic [LEN_W-1:0]  q_len, pos_r, pos_b;
        logic [DATA_W-1:0] sh_r, sh_b;
        logic [DIV_W-1:0]  r_mask;
        s1     = div_step(st2_reg.data, m_wide << 1);
        s0     = div_step(s1[DATA_W-1:0], m_wide);
        q_len  = LEN_W'(st2_reg.q);
        pos_r  = q_len + LEN_W'(1);
        pos_b  = q_len + LEN_W'(cfg.bw);
        sh_r   = st2_reg.data >> pos_r;
        sh_b   = st2_reg.data >> pos_b;
        // low bw-1 ones; none when bw is zero or one
        r_mask = {DIV_W{1'b1}} >> (BW_W'(DIV_W + 1) - cfg.bw);
        st3_next      = '0;
        st3_next.func = st2_reg.func;
        if (st2_reg.func == FUNC_ENCODE) begin
            st3_next.err = st2_reg.err;
            st3_next.q   = {st2_reg.q[5:2], s1[DATA_W], s0[DATA_W]};
            st3_next.r   = s0[DIV_W-1:0];
        end else begin
            st3_next.err  = st2_reg.err || (pos_b > WORD_LEN);
            st3_next.q    = st2_reg.q;
            st3_next.r    = sh_r[DIV_W-1:0] & r_mask;
            st3_next.b    = sh_b[0];
            st3_next.prod = PROD_W'(st2_reg.q) * PROD_W'(cfg.m);
        end
    end

    // ---- stage 4: assemble the result ----
    always_comb begin
        logic              lt;
        logic [LEN_W-1:0]  q_len, len_lt, len_ge, len;
        logic [DIV_W:0]    rp, rv;
        logic [DATA_W-1:0] low_ones, word;
        logic              err;
        q_len    = LEN_W'(st3_reg.q);
        len_lt   = q_len + LEN_W'(cfg.bw);
        len_ge   = len_lt + LEN_W'(1);
        lt       = st3_reg.r < cfg.cutoff;
        rp       = {1'b0, st3_reg.r} + {1'b0, cfg.cutoff};
        rv       = {st3_reg.r, st3_reg.b} - {1'b0, cfg.cutoff};
        low_ones = (DATA_W'(1) << st3_reg.q) - DATA_W'(1);
        len      = lt ? len_lt : len_ge;
        err      = st3_reg.err || (len > WORD_LEN);
        if (st3_reg.func == FUNC_ENCODE) begin
            if (lt) begin
                word = low_ones | (DATA_W'(st3_reg.r) << (q_len + LEN_W'(1)));
            end else begin
                word = low_ones
                     | (DATA_W'(rp[DIV_W-1:1]) << (q_len + LEN_W'(1)))
                     | (DATA_W'(rp[0]) << len_lt);
            end
        end else begin
            if (lt) word = DATA_W'(st3_reg.prod) + DATA_W'(st3_reg.r);
            else    word = DATA_W'(st3_reg.prod) + DATA_W'(rv);
        end
        m_error_next       = err;
        m_result_word_next = err ? '0 : word;
        m_bit_length_next  = err ? '0 : len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= s_valid;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) st1_reg <= st1_next;
        if (rdy2) st2_reg <= st2_next;
        if (rdy3) st3_reg <= st3_next;
        if (rdy4) begin
            m_result_word_reg <= m_result_word_next;
            m_bit_length_reg  <= m_bit_length_next;
            m_error_reg       <= m_error_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_word = m_result_word_reg;
    assign m_bit_length  = m_bit_length_reg;
    assign m_error       = m_error_reg;

endmodule
